### hdl/uule_pkg.sv
// shared constants for the uuencode line encoder
`timescale 1ns / 1ps
package uule_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned GroupW   = 3 * ByteW;
  localparam int unsigned SextetW  = 6;
  localparam int unsigned CountW   = 6;

  localparam logic [ByteW-1:0] CharOffset  = 8'd32;
  localparam logic [ByteW-1:0] NewlineChar = 8'd10;

endpackage

### hdl/uule_if.sv
// stream channel interfaces for input bytes and output characters
`timescale 1ns / 1ps
interface uule_in_if
  import uule_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             is_final;

  modport source (output valid, output data_byte, output is_final, input ready);
  modport sink   (input valid, input data_byte, input is_final, output ready);
endinterface

interface uule_out_if
  import uule_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_char;
  logic             run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

### hdl/uule_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module uule_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 15,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/uuencode_line_encoder.sv
// top level of the uuencode line encoder
// an input byte is taken while idle; bytes that close no line give no beats
// a closing byte gives 4 beats per group plus the length char and newline,
// one per cycle unless stalled, via shared offset adder, row-per-group store
// the input is not ready from the closing byte until the newline is loaded
// async active-low reset clears the sequencer, byte counters and output valid
`timescale 1ns / 1ps
module uuencode_line_encoder
  import uule_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 45
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  uule_in_if.sink    in_i,
  uule_out_if.source out_o
);

  localparam int unsigned StoreGroups = (LINE_BYTES + 2) / 3;
  localparam int unsigned AddrW = (StoreGroups > 1) ? $clog2(StoreGroups) : 1;
  localparam int unsigned CntW  = $clog2(StoreGroups + 1);
  localparam logic [CountW-1:0] LineBytesC = CountW'(LINE_BYTES);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLen  = 2'd1;
  localparam logic [1:0] StData = 2'd2;
  localparam logic [1:0] StNl   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [15:0]       held_q, held_d;
  logic [1:0]        held_cnt_q, held_cnt_d;
  logic [CountW-1:0] lbc_q, lbc_d;
  logic [CntW-1:0]   grp_q, grp_d;
  logic [CountW-1:0] len_q, len_d;
  logic [CntW-1:0]   rows_q, rows_d;
  logic [CntW-1:0]   row_q, row_d;
  logic [1:0]        chr_q, chr_d;
  logic              out_valid_q, out_valid_d;
  logic [ByteW-1:0]  out_char_q, out_char_d;
  logic              out_last_q, out_last_d;

  logic              accept, close, load, out_free;
  logic [CountW-1:0] lbc_inc;
  logic              we;
  logic [GroupW-1:0] wdata, rdata;
  logic [SextetW-1:0] field;
  logic [ByteW-1:0]  add_a, add_sum;

  assign in_i.ready = (state_q == StIdle);
  assign accept     = in_i.valid && in_i.ready;
  assign lbc_inc    = lbc_q + CountW'(1);
  assign close      = in_i.is_final || (lbc_inc == LineBytesC);
  assign out_free   = !out_valid_q || out_o.ready;
  assign load       = (state_q != StIdle) && out_free;

  always_comb begin
    case (held_cnt_q)
      2'd2:    wdata = {held_q, in_i.data_byte};
      2'd1:    wdata = {held_q[7:0], in_i.data_byte, 8'h00};
      default: wdata = {in_i.data_byte, 16'h0000};
    endcase
  end

  assign we = accept && ((held_cnt_q == 2'd2) || close);

  uule_ram #(
    .Width (GroupW),
    .Depth (StoreGroups)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (grp_q[AddrW-1:0]),
    .wdata_i (wdata),
    .raddr_i (row_d[AddrW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    case (chr_q)
      2'd0:    field = rdata[23:18];
      2'd1:    field = rdata[17:12];
      2'd2:    field = rdata[11:6];
      default: field = rdata[5:0];
    endcase
  end

  // shared offset adder for length and data characters
  assign add_a   = (state_q == StLen) ? {2'b00, len_q} : {2'b00, field};
  assign add_sum = add_a + CharOffset;

  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    held_cnt_d  = held_cnt_q;
    lbc_d       = lbc_q;
    grp_d       = grp_q;
    len_d       = len_q;
    rows_d      = rows_q;
    row_d       = row_q;
    chr_d       = chr_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    if (accept) begin
      lbc_d = lbc_inc;
      case (held_cnt_q)
        2'd2: begin
          held_d     = 16'h0000;
          held_cnt_d = 2'd0;
          grp_d      = grp_q + CntW'(1);
        end
        2'd1: begin
          held_d     = {held_q[7:0], in_i.data_byte};
          held_cnt_d = 2'd2;
        end
        default: begin
          held_d     = {8'h00, in_i.data_byte};
          held_cnt_d = 2'd1;
        end
      endcase
      if (close) begin
        len_d      = lbc_inc;
        rows_d     = grp_q + CntW'(1);
        row_d      = '0;
        chr_d      = 2'd0;
        held_d     = 16'h0000;
        held_cnt_d = 2'd0;
        lbc_d      = '0;
        grp_d      = '0;
        state_d    = StLen;
      end
    end

    if (load) begin
      out_valid_d = 1'b1;
      out_last_d  = 1'b0;
      out_char_d  = add_sum;
      case (state_q)
        StLen: begin
          state_d = StData;
        end
        StData: begin
          chr_d = chr_q + 2'd1;
          if (chr_q == 2'd3) begin
            if (row_q == rows_q - CntW'(1)) begin
              state_d = StNl;
            end else begin
              row_d = row_q + CntW'(1);
            end
          end
        end
        StNl: begin
          out_char_d = NewlineChar;
          out_last_d = 1'b1;
          state_d    = StIdle;
        end
        default: begin
          state_d = StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      held_cnt_q  <= 2'd0;
      held_q      <= 16'h0000;
      lbc_q       <= '0;
      grp_q       <= '0;
      row_q       <= '0;
      chr_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_cnt_q  <= held_cnt_d;
      held_q      <= held_d;
      lbc_q       <= lbc_d;
      grp_q       <= grp_d;
      row_q       <= row_d;
      chr_q       <= chr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q      <= len_d;
    rows_q     <= rows_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_char = out_char_q;
  assign out_o.run_last = out_last_q;

endmodule
